// ===== hw/rtl/bcda_pkg.sv =====
// Shared types, constants and helper functions of the binary clock dot animator.
`timescale 1ns / 1ps

package bcda_pkg;

    localparam int NUM_COLUMNS = 6;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_DOTS    = NUM_COLUMNS * NUM_ROWS;

    localparam logic [15:0] FULL = 16'd16384;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    localparam logic [2:0] REG_POP_DUR   = 3'd0;
    localparam logic [2:0] REG_GLOW_DUR  = 3'd1;
    localparam logic [2:0] REG_STAGGER   = 3'd2;
    localparam logic [2:0] REG_RIPPLE    = 3'd3;
    localparam logic [2:0] REG_PEAK      = 3'd4;
    localparam logic [2:0] REG_OVERSHOOT = 3'd5;

    typedef struct packed {
        logic [15:0] pop_dur;
        logic [15:0] glow_dur;
        logic [15:0] stagger;
        logic [15:0] ripple;
        logic [13:0] peak;
        logic [13:0] over;
    } cfg_t;

    // one dot as handed to the fade engine
    typedef struct packed {
        logic        lit;
        logic        anim;
        logic [15:0] level;
        logic [15:0] from;
        logic [31:0] start;
    } dot_req_t;

    typedef struct packed {
        logic        done;
        logic        anim;
        logic [15:0] level;
    } dot_rsp_t;

    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd50)
            t = 3'd5;
        else if (v >= 6'd40)
            t = 3'd4;
        else if (v >= 6'd30)
            t = 3'd3;
        else if (v >= 6'd20)
            t = 3'd2;
        else if (v >= 6'd10)
            t = 3'd1;
        else
            t = 3'd0;
        return t;
    endfunction

    // Target pattern of all dots, bit c*4+r, row 0 carries weight 8
    function automatic logic [NUM_DOTS-1:0] dot_pattern(input logic [4:0] h,
                                                        input logic [5:0] m,
                                                        input logic [5:0] s);
        logic [5:0]          hh;
        logic [5:0]          mm;
        logic [5:0]          ss;
        logic [3:0]          dg [NUM_COLUMNS];
        logic [2:0]          tn;
        logic [NUM_DOTS-1:0] pat;
        hh = (h >= 5'd24) ? {1'b0, h - 5'd24} : {1'b0, h};
        mm = (m >= 6'd60) ? m - 6'd60 : m;
        ss = (s >= 6'd60) ? s - 6'd60 : s;
        tn = tens_of(hh);
        dg[0] = {1'b0, tn};
        dg[1] = 4'(hh - 6'(tn) * 6'd10);
        tn = tens_of(mm);
        dg[2] = {1'b0, tn};
        dg[3] = 4'(mm - 6'(tn) * 6'd10);
        tn = tens_of(ss);
        dg[4] = {1'b0, tn};
        dg[5] = 4'(ss - 6'(tn) * 6'd10);
        for (int c = 0; c < NUM_COLUMNS; c++)
            for (int r = 0; r < NUM_ROWS; r++)
                pat[c * NUM_ROWS + r] = dg[c][3 - r];
        return pat;
    endfunction

endpackage

// ===== hw/rtl/binary_clock_dot_animator_unit.sv =====
// Top level of the binary clock dot animator: control, dot state, ports.
`timescale 1ns / 1ps

// A time update walks all 24 dots through the fade engine, retargets them,
// walks them again and then sends 24 results, column by column, with tlast
// on the final dot. The fade engine sets the pace: a dot that is not fading
// passes straight through; a fading dot takes longer, and longer still when
// popping than when going dark, since every division gives one bit and
// every multiplication takes one multiplier bit per cycle. Results are held
// while m_tready is low. Load and clear requests give no results. Input
// requests are taken only while no update is in progress.

module binary_clock_dot_animator_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // hour[4:0], minute[10:5], second[16:11], now_ms[48:17]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // dot_column[2:0], dot_row[4:3], dot_level[20:5], dot_lit[21]
    output logic        m_tlast,   // last_dot
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ND = bcda_pkg::NUM_DOTS;

    typedef enum logic [2:0] {
        T_IDLE, T_ADV, T_RINIT, T_RET, T_OUT
    } tstate_t;

    tstate_t            state_reg;
    bcda_pkg::cfg_t     cfg_reg;
    logic [ND-1:0]      target_reg;
    logic [ND-1:0]      anim_reg;
    logic [15:0]        bright_reg [ND];
    logic [15:0]        from_reg [ND];
    logic [31:0]        start_reg [ND];
    logic               pending_reg;
    logic [31:0]        load_start_reg;
    logic [31:0]        now_reg;
    logic [ND-1:0]      pat_reg;
    logic [4:0]         idx_reg;
    logic               pass_reg;
    logic               eng_go_reg;
    logic               load_mode_reg;
    logic [2:0]         col_reg;
    logic [31:0]        rtime_reg;
    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;
    logic               m_tlast_reg;

    bcda_pkg::dot_req_t eng_req;
    bcda_pkg::dot_rsp_t eng_rsp;
    logic               any_change;
    logic [2:0]         last_col;
    logic               s_take;
    logic               out_free;

    assign eng_req = '{lit: target_reg[idx_reg], anim: anim_reg[idx_reg],
                       level: bright_reg[idx_reg], from: from_reg[idx_reg],
                       start: start_reg[idx_reg]};

    bcda_engine u_engine (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (eng_go_reg),
        .req  (eng_req),
        .now  (now_reg),
        .cfg  (cfg_reg),
        .rsp  (eng_rsp)
    );

    // rightmost column whose target differs from the new time
    always_comb
    begin
        any_change = 1'b0;
        last_col   = '0;
        for (int c = 0; c < bcda_pkg::NUM_COLUMNS; c++)
        begin
            if ((target_reg[c * 4 +: 4] ^ pat_reg[c * 4 +: 4]) != 4'd0)
            begin
                any_change = 1'b1;
                last_col   = 3'(c);
            end
        end
    end

    assign s_tready = (state_reg == T_IDLE);
    assign s_take   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            target_reg     <= '0;
            anim_reg       <= '0;
            pending_reg    <= 1'b0;
            load_start_reg <= '0;
            eng_go_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            idx_reg        <= '0;
            pass_reg       <= 1'b0;
            for (int i = 0; i < ND; i++)
            begin
                bright_reg[i] <= '0;
                from_reg[i]   <= '0;
                start_reg[i]  <= '0;
            end
        end
        else
        begin
            eng_go_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (s_take)
                    begin
                        case (s_tuser)
                            bcda_pkg::CMD_LOAD, bcda_pkg::CMD_CLEAR:
                            begin
                                target_reg  <= '0;
                                anim_reg    <= '0;
                                for (int i = 0; i < ND; i++)
                                begin
                                    bright_reg[i] <= '0;
                                    from_reg[i]   <= '0;
                                    start_reg[i]  <= '0;
                                end
                                pending_reg <= (s_tuser == bcda_pkg::CMD_LOAD);
                                if (s_tuser == bcda_pkg::CMD_LOAD)
                                    load_start_reg <= s_tdata[48:17];
                            end
                            bcda_pkg::CMD_UPDATE:
                            begin
                                now_reg    <= s_tdata[48:17];
                                pat_reg    <= bcda_pkg::dot_pattern(s_tdata[4:0],
                                                                    s_tdata[10:5],
                                                                    s_tdata[16:11]);
                                idx_reg    <= '0;
                                pass_reg   <= 1'b0;
                                eng_go_reg <= 1'b1;
                                state_reg  <= T_ADV;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                T_ADV:
                begin
                    if (eng_rsp.done)
                    begin
                        bright_reg[idx_reg] <= eng_rsp.level;
                        anim_reg[idx_reg]   <= eng_rsp.anim;
                        if (idx_reg == 5'(ND - 1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= pass_reg ? T_OUT : T_RINIT;
                        end
                        else
                        begin
                            idx_reg    <= idx_reg + 5'd1;
                            eng_go_reg <= 1'b1;
                        end
                    end
                end
                T_RINIT:
                begin
                    if (pending_reg)
                    begin
                        pending_reg   <= 1'b0;
                        load_mode_reg <= 1'b1;
                        col_reg       <= '0;
                        rtime_reg     <= load_start_reg;
                        state_reg     <= T_RET;
                    end
                    else if (any_change)
                    begin
                        // carry ripple runs from the rightmost change leftward
                        load_mode_reg <= 1'b0;
                        col_reg       <= last_col;
                        rtime_reg     <= now_reg;
                        state_reg     <= T_RET;
                    end
                    else
                    begin
                        pass_reg   <= 1'b1;
                        eng_go_reg <= 1'b1;
                        state_reg  <= T_ADV;
                    end
                end
                T_RET:
                begin
                    for (int r = 0; r < bcda_pkg::NUM_ROWS; r++)
                    begin
                        if (target_reg[{col_reg, 2'(r)}] != pat_reg[{col_reg, 2'(r)}])
                        begin
                            target_reg[{col_reg, 2'(r)}] <= pat_reg[{col_reg, 2'(r)}];
                            from_reg[{col_reg, 2'(r)}]   <= bright_reg[{col_reg, 2'(r)}];
                            start_reg[{col_reg, 2'(r)}]  <= rtime_reg;
                            anim_reg[{col_reg, 2'(r)}]   <= 1'b1;
                        end
                    end
                    if (load_mode_reg)
                    begin
                        rtime_reg <= rtime_reg + {16'd0, cfg_reg.stagger};
                        col_reg   <= col_reg + 3'd1;
                    end
                    else
                    begin
                        rtime_reg <= rtime_reg + {16'd0, cfg_reg.ripple};
                        col_reg   <= col_reg - 3'd1;
                    end
                    if ((load_mode_reg && col_reg == 3'(bcda_pkg::NUM_COLUMNS - 1)) ||
                        (!load_mode_reg && col_reg == 3'd0))
                    begin
                        pass_reg   <= 1'b1;
                        eng_go_reg <= 1'b1;
                        state_reg  <= T_ADV;
                    end
                end
                T_OUT:
                begin
                    if (out_free)
                    begin
                        if (idx_reg < 5'(ND))
                        begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= {2'd0, target_reg[idx_reg], bright_reg[idx_reg],
                                             idx_reg[1:0], idx_reg[4:2]};
                            m_tlast_reg  <= (idx_reg == 5'(ND - 1));
                            idx_reg      <= idx_reg + 5'd1;
                        end
                        else
                        begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= T_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pop_dur  <= 16'd400;
            cfg_reg.glow_dur <= 16'd300;
            cfg_reg.stagger  <= 16'd80;
            cfg_reg.ripple   <= 16'd60;
            cfg_reg.peak     <= 14'd9830;
            cfg_reg.over     <= 14'd3277;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                bcda_pkg::REG_POP_DUR:   cfg_reg.pop_dur  <= pwdata[15:0];
                bcda_pkg::REG_GLOW_DUR:  cfg_reg.glow_dur <= pwdata[15:0];
                bcda_pkg::REG_STAGGER:   cfg_reg.stagger  <= pwdata[15:0];
                bcda_pkg::REG_RIPPLE:    cfg_reg.ripple   <= pwdata[15:0];
                bcda_pkg::REG_PEAK:      cfg_reg.peak     <= pwdata[13:0];
                bcda_pkg::REG_OVERSHOOT: cfg_reg.over     <= pwdata[13:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            bcda_pkg::REG_POP_DUR:   prdata = {16'd0, cfg_reg.pop_dur};
            bcda_pkg::REG_GLOW_DUR:  prdata = {16'd0, cfg_reg.glow_dur};
            bcda_pkg::REG_STAGGER:   prdata = {16'd0, cfg_reg.stagger};
            bcda_pkg::REG_RIPPLE:    prdata = {16'd0, cfg_reg.ripple};
            bcda_pkg::REG_PEAK:      prdata = {18'd0, cfg_reg.peak};
            bcda_pkg::REG_OVERSHOOT: prdata = {18'd0, cfg_reg.over};
            default:                 prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hw/rtl/bcda_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module bcda_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] a,
    input  logic [15:0] b,
    output logic        done,
    output logic [47:0] prod
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [47:0] a_reg;
    logic [15:0] b_reg;
    logic [47:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                a_reg    <= {16'd0, a};
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (b_reg[0])
                    acc_reg <= acc_reg + a_reg;
                a_reg   <= {a_reg[46:0], 1'b0};
                b_reg   <= {1'b0, b_reg[15:1]};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hw/rtl/bcda_div.sv =====
// Restoring divider giving floor(n * 2^14 / d) for n <= d, one bit per cycle.
`timescale 1ns / 1ps

module bcda_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [15:0] n,
    input  logic [15:0] d,
    output logic        done,
    output logic [14:0] q
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [14:0] q_reg;
    logic        ge;
    logic [16:0] rs;

    assign ge = (r_reg >= {1'b0, d_reg});
    assign rs = ge ? r_reg - {1'b0, d_reg} : r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                r_reg    <= {1'b0, n};
                d_reg    <= d;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // first bit is the integer part, then fourteen fraction bits
                q_reg   <= {q_reg[13:0], ge};
                r_reg   <= {rs[15:0], 1'b0};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd14)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ===== hw/rtl/bcda_engine.sv =====
// Fade engine: advances one dot's brightness to the current time.
`timescale 1ns / 1ps

module bcda_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  bcda_pkg::dot_req_t req,
    input  logic [31:0]       now,
    input  bcda_pkg::cfg_t    cfg,
    output bcda_pkg::dot_rsp_t rsp
);

    typedef enum logic [3:0] {
        E_IDLE, E_T, E_X, E_SQ, E_CUBE, E_POP, E_LIT, E_FADE
    } estate_t;

    estate_t            state_reg;
    bcda_pkg::dot_rsp_t rsp_reg;
    logic               lit_reg;
    logic               tle_reg;
    logic               neg_reg;
    logic [15:0]        from_reg;
    logic [14:0]        x_reg;
    logic               mul_go_reg;
    logic [31:0]        mul_a_reg;
    logic [15:0]        mul_b_reg;
    logic               div_go_reg;
    logic [15:0]        div_n_reg;
    logic [15:0]        div_d_reg;

    logic               mul_done;
    logic [47:0]        prod;
    logic               div_done;
    logic [14:0]        div_q;

    logic [31:0]        el;
    logic [15:0]        span;
    logic [13:0]        peak;
    logic [14:0]        s_w;
    logic [14:0]        ns_w;
    logic [15:0]        pop_w;
    logic [14:0]        xc_w;
    logic [33:0]        base_w;
    logic [33:0]        sum_w;
    logic [15:0]        lit_lvl;

    bcda_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mul_go_reg),
        .a    (mul_a_reg),
        .b    (mul_b_reg),
        .done (mul_done),
        .prod (prod)
    );

    bcda_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go_reg),
        .n    (div_n_reg),
        .d    (div_d_reg),
        .done (div_done),
        .q    (div_q)
    );

    always_comb
    begin
        el     = now - req.start;
        span   = req.lit ? cfg.pop_dur : cfg.glow_dur;
        peak   = (cfg.peak == 14'd0) ? 14'd1 : cfg.peak;
        s_w    = prod[42:28];
        ns_w   = 15'(bcda_pkg::FULL) - s_w;
        pop_w  = tle_reg ? prod[29:14] : bcda_pkg::FULL + prod[29:14];
        xc_w   = (div_q > 15'(bcda_pkg::FULL)) ? 15'(bcda_pkg::FULL) : div_q;
        base_w = {4'd0, from_reg, 14'd0};
        sum_w  = '0;
        lit_lvl = '0;
        if (neg_reg)
        begin
            // level is clamped to zero when the product exceeds the base
            sum_w = base_w - {2'd0, prod[31:0]};
            if ({2'd0, prod[31:0]} > base_w)
                lit_lvl = '0;
            else
                lit_lvl = sum_w[29:14];
        end
        else
        begin
            sum_w = base_w + {2'd0, prod[31:0]};
            if (sum_w[33:30] != 4'd0)
                lit_lvl = 16'hFFFF;
            else
                lit_lvl = sum_w[29:14];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            rsp_reg    <= '0;
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            mul_go_reg   <= 1'b0;
            div_go_reg   <= 1'b0;
            rsp_reg.done <= 1'b0;
            unique case (state_reg)
                E_IDLE:
                begin
                    if (go)
                    begin
                        lit_reg  <= req.lit;
                        from_reg <= req.from;
                        if (!req.anim || el[31])
                        begin
                            rsp_reg <= '{done: 1'b1, anim: req.anim, level: req.level};
                        end
                        else if (el >= {16'd0, span})
                        begin
                            rsp_reg <= '{done: 1'b1, anim: 1'b0,
                                         level: req.lit ? bcda_pkg::FULL : 16'd0};
                        end
                        else
                        begin
                            div_n_reg  <= el[15:0];
                            div_d_reg  <= span;
                            div_go_reg <= 1'b1;
                            state_reg  <= E_T;
                        end
                    end
                end
                E_T:
                begin
                    if (div_done)
                    begin
                        if (!lit_reg)
                        begin
                            x_reg      <= div_q;
                            mul_a_reg  <= {17'd0, div_q};
                            mul_b_reg  <= {1'b0, div_q};
                            mul_go_reg <= 1'b1;
                            state_reg  <= E_SQ;
                        end
                        else if (div_q <= {1'b0, peak})
                        begin
                            tle_reg    <= 1'b1;
                            div_n_reg  <= {1'b0, div_q};
                            div_d_reg  <= {2'd0, peak};
                            div_go_reg <= 1'b1;
                            state_reg  <= E_X;
                        end
                        else
                        begin
                            tle_reg    <= 1'b0;
                            div_n_reg  <= {1'b0, div_q - {1'b0, peak}};
                            div_d_reg  <= bcda_pkg::FULL - {2'd0, peak};
                            div_go_reg <= 1'b1;
                            state_reg  <= E_X;
                        end
                    end
                end
                E_X:
                begin
                    if (div_done)
                    begin
                        x_reg      <= xc_w;
                        mul_a_reg  <= {17'd0, xc_w};
                        mul_b_reg  <= {1'b0, xc_w};
                        mul_go_reg <= 1'b1;
                        state_reg  <= E_SQ;
                    end
                end
                E_SQ:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg  <= {2'd0, prod[29:0]};
                        mul_b_reg  <= 16'(17'd49152 - {1'b0, x_reg, 1'b0});
                        mul_go_reg <= 1'b1;
                        state_reg  <= E_CUBE;
                    end
                end
                E_CUBE:
                begin
                    if (mul_done)
                    begin
                        mul_go_reg <= 1'b1;
                        if (!lit_reg)
                        begin
                            mul_a_reg <= {16'd0, from_reg};
                            mul_b_reg <= {1'b0, ns_w};
                            state_reg <= E_FADE;
                        end
                        else if (tle_reg)
                        begin
                            mul_a_reg <= 32'(bcda_pkg::FULL) + {18'd0, cfg.over};
                            mul_b_reg <= {1'b0, s_w};
                            state_reg <= E_POP;
                        end
                        else
                        begin
                            mul_a_reg <= {18'd0, cfg.over};
                            mul_b_reg <= {1'b0, ns_w};
                            state_reg <= E_POP;
                        end
                    end
                end
                E_POP:
                begin
                    if (mul_done)
                    begin
                        neg_reg    <= (from_reg > bcda_pkg::FULL);
                        mul_a_reg  <= (from_reg > bcda_pkg::FULL)
                                      ? {16'd0, from_reg - bcda_pkg::FULL}
                                      : {16'd0, bcda_pkg::FULL - from_reg};
                        mul_b_reg  <= pop_w;
                        mul_go_reg <= 1'b1;
                        state_reg  <= E_LIT;
                    end
                end
                E_LIT:
                begin
                    if (mul_done)
                    begin
                        rsp_reg   <= '{done: 1'b1, anim: 1'b1, level: lit_lvl};
                        state_reg <= E_IDLE;
                    end
                end
                E_FADE:
                begin
                    if (mul_done)
                    begin
                        rsp_reg   <= '{done: 1'b1, anim: 1'b1, level: prod[29:14]};
                        state_reg <= E_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule
